>>> hw/rtl/fdl_ap_pkg.sv
// ============================================================================
// fdl_ap_pkg
// Shared constants for the fractional delay line with first-order allpass.
// ============================================================================
package fdl_ap_pkg;

    // Configuration register layout
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LEN_WIDTH       = 12;
    localparam int COEF_WIDTH      = 16;
    localparam int COEF_FRAC       = 15;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DELAY_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALLPASS_COEF = 1'b1;

    localparam logic [LEN_WIDTH-1:0]  LEN_RESET  = 12'd2048;
    localparam logic [COEF_WIDTH-1:0] COEF_RESET = 16'd0;

endpackage

>>> hw/rtl/fractional_delay_line_allpass_top.sv
// ============================================================================
// fractional_delay_line_allpass_top
// Circular sample store of programmable length followed by a first-order
// allpass, giving each output sample together with a peek at the next one.
// ============================================================================
// A transaction is never taken in the cycle right after one is taken. The
// allpass feedback loop sets this limit: the coefficient product is
// registered and the saturated sum feeds the previous-output state of the
// following sample, and the store read of the next oldest sample is
// registered at the same edge as the write. The result for a transaction
// waits in a hold register until the product for its peek is ready and the
// output register is free; one further transaction may be taken while that
// result waits. No transaction is taken in the cycle after a configuration
// write. The store needs no clearing pass: a fill count marks the entries
// written since reset and all others read as zero.
module fractional_delay_line_allpass_top #(
    parameter int MAX_DELAY    = 2048,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [fdl_ap_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         s_sample_in,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         m_sample_out,
    output logic signed [SAMPLE_WIDTH-1:0]         m_next_peek
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CW   = $clog2(MAX_DELAY + 1);
    localparam int LCW  = (CW > fdl_ap_pkg::LEN_WIDTH) ? CW : fdl_ap_pkg::LEN_WIDTH;
    localparam int DW   = SW + 1;
    localparam int PW   = fdl_ap_pkg::COEF_WIDTH + DW;
    localparam int ACCW = PW + 2;
    localparam int YW   = ACCW - fdl_ap_pkg::COEF_FRAC;

    localparam logic [LCW-1:0]         MAX_LEN    = LCW'(MAX_DELAY);
    localparam logic signed [ACCW-1:0] ROUND_HALF = ACCW'(1) <<< (fdl_ap_pkg::COEF_FRAC - 1);
    localparam logic signed [YW-1:0]   Y_MAX      = {{(YW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [YW-1:0]   Y_MIN      = ~Y_MAX;

    // Sample store
    logic [SW-1:0] mem [MAX_DELAY];
    logic [SW-1:0] rd_data_reg;

    // Configuration
    logic [fdl_ap_pkg::LEN_WIDTH-1:0]         len_reg,  len_next;
    logic signed [fdl_ap_pkg::COEF_WIDTH-1:0] coef_reg, coef_next;

    // Line and allpass state
    logic [AW-1:0]          pos_reg,  pos_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic signed [SW-1:0]   head_reg, head_next;
    logic signed [SW-1:0]   xp_reg,   xp_next;
    logic signed [SW-1:0]   yp_reg,   yp_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic                   prod_ok_reg, prod_ok_next;
    logic                   load_reg,    load_next;
    logic                   rd_zero_reg, rd_zero_next;
    logic                   rd_fwd_reg,  rd_fwd_next;
    logic signed [SW-1:0]   fwd_data_reg, fwd_data_next;

    // Result holding
    logic                   pending_reg, pending_next;
    logic signed [SW-1:0]   y_hold_reg,  y_hold_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [SW-1:0]   out_y_reg,   out_y_next;
    logic signed [SW-1:0]   out_pk_reg,  out_pk_next;

    logic                   accept;
    logic                   move;
    logic [LCW-1:0]         len_wide;
    logic [CW-1:0]          len_eff;
    logic [CW-1:0]          pos_inc;
    logic [CW-1:0]          next_pos;
    logic [CW-1:0]          fill_upd;
    logic signed [SW-1:0]   rd_value;
    logic signed [SW-1:0]   head_op;
    logic signed [DW-1:0]   diff;
    logic signed [ACCW-1:0] acc;
    logic signed [YW-1:0]   y_wide;
    logic signed [SW-1:0]   ap_comb;

    // Allpass of the current state: registered coefficient product, then
    // round half up and saturate.
    always_comb begin
        acc    = ACCW'(prod_reg) + (ACCW'(xp_reg) <<< fdl_ap_pkg::COEF_FRAC) + ROUND_HALF;
        y_wide = YW'(acc >>> fdl_ap_pkg::COEF_FRAC);
        if (y_wide > Y_MAX) begin
            ap_comb = Y_MAX[SW-1:0];
        end else if (y_wide < Y_MIN) begin
            ap_comb = Y_MIN[SW-1:0];
        end else begin
            ap_comb = y_wide[SW-1:0];
        end
    end

    always_comb begin
        // clamp length to 1..MAX_DELAY
        len_wide = LCW'(len_reg);
        if (len_wide == '0) begin
            len_eff = CW'(1);
        end else if (len_wide > MAX_LEN) begin
            len_eff = CW'(MAX_LEN);
        end else begin
            len_eff = CW'(len_wide);
        end

        pos_inc  = CW'(pos_reg) + CW'(1);
        next_pos = (pos_inc >= len_eff) ? '0 : pos_inc;
        fill_upd = (pos_inc > fill_reg) ? pos_inc : fill_reg;

        if (rd_zero_reg) begin
            rd_value = '0;
        end else if (rd_fwd_reg) begin
            rd_value = fwd_data_reg;
        end else begin
            rd_value = rd_data_reg;
        end
        head_op = load_reg ? rd_value : head_reg;
        diff    = DW'(head_op) - DW'(yp_reg);
    end

    assign move    = pending_reg && prod_ok_reg && (!m_valid_reg || m_ready);
    assign s_ready = prod_ok_reg && (!pending_reg || move);
    assign accept  = s_valid && s_ready;

    always_comb begin
        len_next      = len_reg;
        coef_next     = coef_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        head_next     = head_op;
        xp_next       = xp_reg;
        yp_next       = yp_reg;
        prod_next     = PW'(coef_reg) * PW'(diff);
        prod_ok_next  = !(accept || cfg_wr_en);
        load_next     = 1'b0;
        rd_zero_next  = rd_zero_reg;
        rd_fwd_next   = rd_fwd_reg;
        fwd_data_next = fwd_data_reg;
        pending_next  = pending_reg;
        y_hold_next   = y_hold_reg;
        m_valid_next  = m_valid_reg;
        out_y_next    = out_y_reg;
        out_pk_next   = out_pk_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                fdl_ap_pkg::CFG_DELAY_LENGTH: len_next  = cfg_wdata[fdl_ap_pkg::LEN_WIDTH-1:0];
                fdl_ap_pkg::CFG_ALLPASS_COEF: coef_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (move) begin
            m_valid_next = 1'b1;
            out_y_next   = y_hold_reg;
            out_pk_next  = ap_comb;
            pending_next = 1'b0;
        end

        if (accept) begin
            pending_next  = 1'b1;
            y_hold_next   = ap_comb;
            xp_next       = head_reg;
            yp_next       = ap_comb;
            pos_next      = next_pos[AW-1:0];
            fill_next     = fill_upd;
            load_next     = 1'b1;
            // entries past the fill count were never written: read as zero
            rd_zero_next  = (next_pos >= fill_upd);
            rd_fwd_next   = (next_pos == CW'(pos_reg));
            fwd_data_next = s_sample_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= fdl_ap_pkg::LEN_RESET;
            coef_reg     <= fdl_ap_pkg::COEF_RESET;
            pos_reg      <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            xp_reg       <= '0;
            yp_reg       <= '0;
            prod_ok_reg  <= 1'b0;
            load_reg     <= 1'b0;
            rd_zero_reg  <= 1'b1;
            rd_fwd_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            coef_reg     <= coef_next;
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            xp_reg       <= xp_next;
            yp_reg       <= yp_next;
            prod_ok_reg  <= prod_ok_next;
            load_reg     <= load_next;
            rd_zero_reg  <= rd_zero_next;
            rd_fwd_reg   <= rd_fwd_next;
            pending_reg  <= pending_next;
            m_valid_reg  <= m_valid_next;
        end
        prod_reg     <= prod_next;
        fwd_data_reg <= fwd_data_next;
        y_hold_reg   <= y_hold_next;
        out_y_reg    <= out_y_next;
        out_pk_reg   <= out_pk_next;
    end

    // Write the new sample over the oldest, fetch the next oldest
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[pos_reg]  <= s_sample_in;
            rd_data_reg   <= mem[next_pos[AW-1:0]];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_y_reg;
    assign m_next_peek  = out_pk_reg;

endmodule

>>> verif/fractional_delay_line_allpass_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional delay line with allpass: block-level test
// Drives audio samples through the valid/ready input channel and checks each
// output transaction (delayed allpass sample plus peek) against a cycle-free
// model of the store and allpass kept in this file. A short table of directed
// rows comes first, followed by random phases with fresh register settings and
// different amounts of idling on both channels.
// ----------------------------------------------------------------------------
module fractional_delay_line_allpass_top_test;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_DEPTH = 2048;
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] peek;
    } tap_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_FIXED} row_kind_t;

    typedef struct packed {
        row_kind_t                               kind;
        logic [fdl_ap_pkg::CFG_INDEX_WIDTH-1:0]  idx;
        logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0]   data;
        logic [SAMPLE_W-1:0]                     exp_y;
        logic [SAMPLE_W-1:0]                     exp_peek;
    } stim_row_t;

    typedef enum int {PACE_FULL, PACE_TX_GAPS, PACE_RX_STALLS, PACE_BOTH} pace_t;

    localparam int DIR_ROWS = 29;
    localparam int PHASES   = 10;

    // fixed expectations only where the coefficient is zero, so y is the previous oldest
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_SAMPLE_FIXED, fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h7fff, 16'h0000, 16'h0000},
        '{ROW_SAMPLE_FIXED, fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0001, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h1234, 16'h0000, 16'h0000},
        '{ROW_SAMPLE_FIXED, fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0001, 16'h0000, 16'h7fff},
        '{ROW_SAMPLE_FIXED, fdl_ap_pkg::CFG_DELAY_LENGTH, 16'hffff, 16'h7fff, 16'h0001},
        '{ROW_CFG,          fdl_ap_pkg::CFG_ALLPASS_COEF, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h7fff, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_ALLPASS_COEF, 16'h7fff, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h7fff, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h5555, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'haaaa, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_DELAY_LENGTH, 16'hffff, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h7fff, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0003, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h4000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'hc000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0001, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'hfffe, 16'h0000, 16'h0000},
        '{ROW_CFG,          fdl_ap_pkg::CFG_ALLPASS_COEF, 16'h4000, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0001, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'h0003, 16'h0000, 16'h0000},
        '{ROW_SAMPLE,       fdl_ap_pkg::CFG_DELAY_LENGTH, 16'hffff, 16'h0000, 16'h0000}
    };

    logic                                    aclk      = 1'b0;
    logic                                    aresetn   = 1'b0;
    logic                                    cfg_wr_en = 1'b0;
    logic [fdl_ap_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata = '0;
    logic                                    s_valid   = 1'b0;
    logic                                    s_ready;
    logic signed [SAMPLE_W-1:0]              s_sample_in = '0;
    logic                                    m_valid;
    logic                                    m_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0]              m_sample_out;
    logic signed [SAMPLE_W-1:0]              m_next_peek;

    // model state
    logic signed [SAMPLE_W-1:0]              line_mem [MAX_DEPTH];
    int unsigned                             rd_pos;
    logic signed [SAMPLE_W-1:0]              ap_x1;
    logic signed [SAMPLE_W-1:0]              ap_y1;
    logic [fdl_ap_pkg::LEN_WIDTH-1:0]        len_reg;
    logic signed [fdl_ap_pkg::COEF_WIDTH-1:0] coef_reg;

    tap_t expected_taps [$];
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   tx_idle_pct    = 0;
    int   rx_stall_pct   = 0;

    fractional_delay_line_allpass_top #(
        .MAX_DELAY    (MAX_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_next_peek  (m_next_peek)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] allpass_eval(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] xp,
        input logic signed [SAMPLE_W-1:0] yp
    );
        longint acc;
        longint y;
        acc = longint'(coef_reg) * longint'(x) - longint'(coef_reg) * longint'(yp)
            + (longint'(xp) <<< fdl_ap_pkg::COEF_FRAC)
            + (longint'(1) <<< (fdl_ap_pkg::COEF_FRAC - 1));
        // arithmetic shift floors, which gives round half up with the bias above
        y = acc >>> fdl_ap_pkg::COEF_FRAC;
        if (y > SAT_HI) y = SAT_HI;
        else if (y < SAT_LO) y = SAT_LO;
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic tap_t delay_line_step(input logic signed [SAMPLE_W-1:0] x);
        int unsigned len;
        int unsigned pos;
        int unsigned nxt;
        logic signed [SAMPLE_W-1:0] oldest;
        tap_t r;
        len = (len_reg == 0) ? 1 : ((len_reg > MAX_DEPTH) ? MAX_DEPTH : len_reg);
        pos = (rd_pos >= MAX_DEPTH) ? 0 : rd_pos;
        oldest = line_mem[pos];
        r.y = allpass_eval(oldest, ap_x1, ap_y1);
        ap_x1 = oldest;
        ap_y1 = r.y;
        line_mem[pos] = x;
        // a shrunken length still reads the old position once, then wraps
        nxt = pos + 1;
        if (nxt >= len) nxt = 0;
        rd_pos = nxt;
        r.peek = allpass_eval(line_mem[nxt], ap_x1, ap_y1);
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 60) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic wait_line_idle();
        s_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [fdl_ap_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0] data);
        wait_line_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == fdl_ap_pkg::CFG_DELAY_LENGTH) len_reg = data[fdl_ap_pkg::LEN_WIDTH-1:0];
        else coef_reg = data;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit use_fixed,
                               input tap_t fixed_tap);
        tap_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_sample_in <= value;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = delay_line_step(value);
        expected_taps.push_back(use_fixed ? fixed_tap : predicted);
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                tx_idle_pct = 0;  rx_stall_pct = 0;
            end
            PACE_TX_GAPS: begin
                tx_idle_pct = 70; rx_stall_pct = 0;
            end
            PACE_RX_STALLS: begin
                tx_idle_pct = 0;  rx_stall_pct = 70;
            end
            default: begin
                tx_idle_pct = 35; rx_stall_pct = 35;
            end
        endcase
    endtask

    function automatic logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0] pick_length();
        logic [fdl_ap_pkg::CFG_DATA_WIDTH-fdl_ap_pkg::LEN_WIDTH-1:0] junk;
        junk = (fdl_ap_pkg::CFG_DATA_WIDTH - fdl_ap_pkg::LEN_WIDTH)'($urandom);
        // upper data bits are outside the register and must be ignored
        case ($urandom_range(7))
            0:       return {junk, 12'd1};
            1:       return {junk, 12'd0};
            2:       return {junk, 12'd2048};
            3:       return {junk, 12'($urandom_range(4095, 2049))};
            4, 5:    return {junk, 12'($urandom_range(16, 2))};
            default: return {junk, 12'($urandom_range(300, 17))};
        endcase
    endfunction

    function automatic logic [fdl_ap_pkg::CFG_DATA_WIDTH-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        tap_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_taps.size() == 0) begin
                log_mismatch($sformatf("result %0d arrived with nothing expected",
                                       results_seen));
            end else begin
                want = expected_taps.pop_front();
                if (m_sample_out !== want.y)
                    log_mismatch($sformatf("result %0d sample_out: expected %0d got %0d",
                                           results_seen, want.y, m_sample_out));
                if (m_next_peek !== want.peek)
                    log_mismatch($sformatf("result %0d next_peek: expected %0d got %0d",
                                           results_seen, want.peek, m_next_peek));
            end
            results_seen++;
        end
    end

    initial begin : stimulus
        tap_t typed;
        int   n_items;
        for (int i = 0; i < MAX_DEPTH; i++) line_mem[i] = '0;
        rd_pos   = 0;
        ap_x1    = '0;
        ap_y1    = '0;
        len_reg  = fdl_ap_pkg::LEN_RESET;
        coef_reg = fdl_ap_pkg::COEF_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_pace(PACE_FULL);
        for (int i = 0; i < DIR_ROWS; i++) begin
            typed.y    = DIR_TABLE[i].exp_y;
            typed.peek = DIR_TABLE[i].exp_peek;
            case (DIR_TABLE[i].kind)
                ROW_CFG:          write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
                ROW_SAMPLE:       send_sample(DIR_TABLE[i].data, 1'b0, typed);
                ROW_SAMPLE_FIXED: send_sample(DIR_TABLE[i].data, 1'b1, typed);
                default: ;
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            set_pace(pace_t'(ph % 4));
            write_reg(fdl_ap_pkg::CFG_DELAY_LENGTH, pick_length());
            write_reg(fdl_ap_pkg::CFG_ALLPASS_COEF, pick_coef());
            n_items = $urandom_range(170, 140);
            for (int k = 0; k < n_items; k++) send_sample(pick_sample(), 1'b0, typed);
        end

        wait_line_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_taps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
